// ===== rtl/core/sbrr_pkg.sv =====
// shared constants for the signature bypass rrip replacement block
// used by the top level and the signature counter memory
`default_nettype none
package sbrr_pkg;
    localparam int NUM_SETS    = 2048;
    localparam int NUM_WAYS    = 16;
    localparam int SIG_ENTRIES = 16384;
    localparam int SET_W       = 11;
    localparam int WAY_W       = 4;
    localparam int SIG_W       = 14;
    localparam int TOUCH_W     = 64;

    localparam logic [1:0]  RRPV_MAX  = 2'd3;
    localparam logic [1:0]  RRPV_COLD = 2'd2;
    localparam logic [1:0]  RRPV_HOT  = 2'd0;
    localparam logic [1:0]  CTR_MAX   = 2'd3;
    localparam logic [1:0]  CTR_RESET = 2'd1;
    localparam logic [31:0] TIMEOUT_RESET = 32'd10000;
    localparam logic [4:0]  BYPASS_WAY = 5'd16;

    typedef struct packed {
        logic             rd_en;
        logic [SIG_W-1:0] rd_addr;
        logic             wr_en;
        logic [SIG_W-1:0] wr_addr;
        logic [1:0]       wr_data;
    } ctr_req_t;
endpackage
`default_nettype wire

// ===== rtl/core/sbrr_ctr_mem.sv =====
// signature reuse counter table, 2 bits per signature
// one read and one write port, registered read data; uses sbrr_pkg
`default_nettype none
module sbrr_ctr_mem
    import sbrr_pkg::*;
(
    input  wire logic       clk,
    input  wire ctr_req_t   req,
    output logic [1:0]      rd_data
);
    logic [1:0] ctr_mem [SIG_ENTRIES];
    logic [1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            ctr_mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= ctr_mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule
`default_nettype wire

// ===== rtl/core/signature_bypass_rrip_replacement.sv =====
// After reset the block clears its tables (one signature counter, and one set row while
// the sweep is below 2048, per cycle) and takes no access meanwhile. A miss on a full
// set scans every way before aging: the idle-time check runs one way per cycle through
// a single 64-bit subtract and compare. Set rows are read and written whole, through
// one read port and one write port. The result sits in an output register; the next
// access is taken while it waits.
`default_nettype none
module signature_bypass_rrip_replacement
    import sbrr_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [31:0]  cfg_data,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire logic [10:0]  set_index,
    input  wire logic [63:0]  pc,
    input  wire logic         is_prefetch,
    input  wire logic         hit,
    input  wire logic [3:0]   hit_way,
    input  wire logic [15:0]  line_valid_mask,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic [4:0]        chosen_way,
    output logic              bypassed
);
    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_LOAD, ST_HIT_UPD, ST_BYPASS, ST_SCAN, ST_AGE,
        ST_EVICT, ST_EV_RD, ST_INSERT
    } state_t;

    typedef logic [NUM_WAYS-1:0][1:0]       rrpv_row_t;
    typedef logic [NUM_WAYS-1:0][SIG_W-1:0] sig_row_t;
    typedef logic [NUM_WAYS-1:0][TOUCH_W-1:0] touch_row_t;

    // set row memories
    rrpv_row_t           rrpv_mem  [NUM_SETS];
    logic [NUM_WAYS-1:0] valid_mem [NUM_SETS];
    logic [NUM_WAYS-1:0] reref_mem [NUM_SETS];
    sig_row_t            sig_mem   [NUM_SETS];
    touch_row_t          touch_mem [NUM_SETS];

    rrpv_row_t           rd_rrpv_reg;
    logic [NUM_WAYS-1:0] rd_valid_reg;
    logic [NUM_WAYS-1:0] rd_reref_reg;
    sig_row_t            rd_sig_reg;
    touch_row_t          rd_touch_reg;

    state_t              state_reg;
    logic [SIG_W-1:0]    clr_cnt_reg;
    logic [31:0]         timeout_reg;
    logic [63:0]         clock_reg;
    logic [SET_W-1:0]    set_reg;
    logic [SIG_W-1:0]    sig_reg;
    logic                pref_reg;
    logic                hit_reg;
    logic [WAY_W-1:0]    way_reg;
    logic [NUM_WAYS-1:0] mask_reg;
    logic [1:0]          ctr_new_reg;
    logic                dec_reg;
    logic [1:0]          dec_val_reg;
    rrpv_row_t           rrpv_w_reg;
    logic [NUM_WAYS-1:0] valid_w_reg;
    logic [NUM_WAYS-1:0] reref_w_reg;
    sig_row_t            sig_w_reg;
    touch_row_t          touch_w_reg;
    logic                out_valid_reg;
    logic [4:0]          chosen_way_reg;
    logic                bypassed_reg;

    ctr_req_t            ctr_req;
    logic [1:0]          ctr_rd;

    logic                out_free;
    logic                out_load;
    logic                row_re;
    logic                row_we;
    logic [SET_W-1:0]    row_waddr;
    rrpv_row_t           row_rrpv;
    logic [NUM_WAYS-1:0] row_valid;
    logic [NUM_WAYS-1:0] row_reref;
    sig_row_t            row_sig;
    touch_row_t          row_touch;
    logic [SIG_W-1:0]    in_sig;
    logic [63:0]         idle_time;
    logic                expired;
    logic [1:0]          top;
    logic [1:0]          lift;
    rrpv_row_t           lifted;
    logic [WAY_W-1:0]    aged_victim;
    logic                has_free;
    logic [WAY_W-1:0]    free_way;
    logic [1:0]          ins_ctr;

    sbrr_ctr_mem u_ctr (
        .clk     (clk),
        .req     (ctr_req),
        .rd_data (ctr_rd)
    );

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign chosen_way = chosen_way_reg;
    assign bypassed  = bypassed_reg;
    assign out_free  = !out_valid_reg || out_ready;
    // a new result beat is loaded this cycle
    assign out_load  = out_free && (state_reg inside {ST_HIT_UPD, ST_BYPASS, ST_INSERT});
    assign in_sig    = pc[SIG_W-1:0] ^ pc[16+SIG_W-1:16];

    // shared idle-time unit, one way per cycle
    assign idle_time = clock_reg - touch_w_reg[way_reg];
    assign expired   = valid_w_reg[way_reg] && (idle_time >= {32'd0, timeout_reg});

    always_comb
    begin
        has_free = 1'b0;
        free_way = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--)
        begin
            if (!mask_reg[w])
            begin
                has_free = 1'b1;
                free_way = WAY_W'(w);
            end
        end
    end

    always_comb
    begin
        top = '0;
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            if (rrpv_w_reg[w] > top)
            begin
                top = rrpv_w_reg[w];
            end
        end
        lift = RRPV_MAX - top;
        aged_victim = '0;
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            lifted[w] = rrpv_w_reg[w] + lift;
        end
        for (int w = NUM_WAYS - 1; w >= 0; w--)
        begin
            if (lifted[w] == RRPV_MAX)
            begin
                aged_victim = WAY_W'(w);
            end
        end
    end

    // counter that decides insertion, after a possible eviction decrement
    assign ins_ctr = (dec_reg && (sig_w_reg[way_reg] == sig_reg)) ? dec_val_reg : ctr_new_reg;

    // memory port control
    always_comb
    begin
        ctr_req   = '0;
        row_re    = 1'b0;
        row_we    = 1'b0;
        row_waddr = set_reg;
        row_rrpv  = rrpv_w_reg;
        row_valid = valid_w_reg;
        row_reref = reref_w_reg;
        row_sig   = sig_w_reg;
        row_touch = touch_w_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ctr_req.wr_en   = 1'b1;
                ctr_req.wr_addr = clr_cnt_reg;
                ctr_req.wr_data = CTR_RESET;
                row_we    = (clr_cnt_reg < SIG_W'(NUM_SETS));
                row_waddr = clr_cnt_reg[SET_W-1:0];
                row_rrpv  = {NUM_WAYS{RRPV_MAX}};
                row_valid = '0;
                row_reref = '0;
                row_sig   = '0;
                row_touch = '0;
            end
            ST_IDLE:
            begin
                row_re          = in_valid;
                ctr_req.rd_en   = in_valid;
                ctr_req.rd_addr = in_sig;
            end
            ST_LOAD:
            begin
                ctr_req.rd_en   = hit_reg;
                ctr_req.rd_addr = rd_sig_reg[way_reg];
            end
            ST_HIT_UPD:
            begin
                ctr_req.wr_en   = out_free;
                ctr_req.wr_addr = sig_w_reg[way_reg];
                ctr_req.wr_data = (ctr_rd < CTR_MAX) ? ctr_rd + 2'd1 : ctr_rd;
                row_we = out_free;
                row_rrpv[way_reg]  = RRPV_HOT;
                row_touch[way_reg] = clock_reg + 64'd1;
                row_reref[way_reg] = 1'b1;
            end
            ST_EVICT:
            begin
                ctr_req.rd_en   = valid_w_reg[way_reg];
                ctr_req.rd_addr = sig_w_reg[way_reg];
            end
            ST_EV_RD:
            begin
                ctr_req.wr_en   = !reref_w_reg[way_reg] && (ctr_rd != 2'd0);
                ctr_req.wr_addr = sig_w_reg[way_reg];
                ctr_req.wr_data = ctr_rd - 2'd1;
            end
            ST_INSERT:
            begin
                row_we = out_free;
                row_valid[way_reg] = 1'b1;
                row_touch[way_reg] = clock_reg + 64'd1;
                row_sig[way_reg]   = sig_reg;
                row_reref[way_reg] = 1'b0;
                row_rrpv[way_reg]  = (ins_ctr >= 2'd2) ? RRPV_HOT : RRPV_COLD;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (row_we)
        begin
            rrpv_mem[row_waddr]  <= row_rrpv;
            valid_mem[row_waddr] <= row_valid;
            reref_mem[row_waddr] <= row_reref;
            sig_mem[row_waddr]   <= row_sig;
            touch_mem[row_waddr] <= row_touch;
        end
        if (row_re)
        begin
            rd_rrpv_reg  <= rrpv_mem[set_index];
            rd_valid_reg <= valid_mem[set_index];
            rd_reref_reg <= reref_mem[set_index];
            rd_sig_reg   <= sig_mem[set_index];
            rd_touch_reg <= touch_mem[set_index];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_cnt_reg    <= '0;
            timeout_reg    <= TIMEOUT_RESET;
            clock_reg      <= '0;
            out_valid_reg  <= 1'b0;
            chosen_way_reg <= '0;
            bypassed_reg   <= 1'b0;
            dec_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                timeout_reg <= cfg_data;
            end
            if (out_valid_reg && out_ready && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + SIG_W'(1);
                    if (clr_cnt_reg == SIG_W'(SIG_ENTRIES - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        set_reg   <= set_index;
                        sig_reg   <= in_sig;
                        pref_reg  <= is_prefetch;
                        hit_reg   <= hit;
                        way_reg   <= hit_way;
                        mask_reg  <= line_valid_mask;
                        dec_reg   <= 1'b0;
                        state_reg <= ST_LOAD;
                    end
                end
                ST_LOAD:
                begin
                    rrpv_w_reg  <= rd_rrpv_reg;
                    valid_w_reg <= rd_valid_reg;
                    reref_w_reg <= rd_reref_reg;
                    sig_w_reg   <= rd_sig_reg;
                    touch_w_reg <= rd_touch_reg;
                    ctr_new_reg <= ctr_rd;
                    if (hit_reg)
                    begin
                        state_reg <= ST_HIT_UPD;
                    end
                    else if (pref_reg || (ctr_rd == 2'd0))
                    begin
                        state_reg <= ST_BYPASS;
                    end
                    else if (has_free)
                    begin
                        way_reg   <= free_way;
                        state_reg <= ST_EVICT;
                    end
                    else
                    begin
                        way_reg   <= '0;
                        state_reg <= ST_SCAN;
                    end
                end
                ST_HIT_UPD:
                begin
                    if (out_free)
                    begin
                        clock_reg      <= clock_reg + 64'd1;
                        out_valid_reg  <= 1'b1;
                        chosen_way_reg <= {1'b0, way_reg};
                        bypassed_reg   <= 1'b0;
                        state_reg      <= ST_IDLE;
                    end
                end
                ST_BYPASS:
                begin
                    if (out_free)
                    begin
                        clock_reg      <= clock_reg + 64'd1;
                        out_valid_reg  <= 1'b1;
                        chosen_way_reg <= BYPASS_WAY;
                        bypassed_reg   <= 1'b1;
                        state_reg      <= ST_IDLE;
                    end
                end
                ST_SCAN:
                begin
                    if (expired)
                    begin
                        rrpv_w_reg[way_reg] <= RRPV_MAX;
                    end
                    way_reg <= way_reg + WAY_W'(1);
                    if (way_reg == WAY_W'(NUM_WAYS - 1))
                    begin
                        state_reg <= ST_AGE;
                    end
                end
                ST_AGE:
                begin
                    rrpv_w_reg <= lifted;
                    way_reg    <= aged_victim;
                    state_reg  <= ST_EVICT;
                end
                ST_EVICT:
                begin
                    state_reg <= valid_w_reg[way_reg] ? ST_EV_RD : ST_INSERT;
                end
                ST_EV_RD:
                begin
                    dec_reg     <= !reref_w_reg[way_reg] && (ctr_rd != 2'd0);
                    dec_val_reg <= ctr_rd - 2'd1;
                    state_reg   <= ST_INSERT;
                end
                ST_INSERT:
                begin
                    if (out_free)
                    begin
                        clock_reg      <= clock_reg + 64'd1;
                        out_valid_reg  <= 1'b1;
                        chosen_way_reg <= {1'b0, way_reg};
                        bypassed_reg   <= 1'b0;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_bypass_code: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && bypassed) |-> (chosen_way == BYPASS_WAY))
        else $error("bypass beat without bypass way code");

    a_way_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !bypassed) |-> (chosen_way < BYPASS_WAY))
        else $error("inserted or hit beat with way out of range");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second access taken while one is in progress");

    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !in_ready)
        else $error("access taken during table clear");
endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// testbench for signature_bypass_rrip_replacement: random and directed cache accesses
// checked against an in-bench replacement predictor; depends on sbrr_pkg and the rtl
`timescale 1ns / 100ps

module tb_top;
    import sbrr_pkg::*;

    class replacement_scoreboard;
        typedef struct {
            logic [4:0] way;
            logic       byp;
        } pick_t;

        logic [1:0]  rrpv     [NUM_SETS][NUM_WAYS];
        logic        tracked  [NUM_SETS][NUM_WAYS];
        logic [63:0] touched  [NUM_SETS][NUM_WAYS];
        logic [13:0] line_sig [NUM_SETS][NUM_WAYS];
        logic        reused   [NUM_SETS][NUM_WAYS];
        logic [1:0]  reuse_ctr[SIG_ENTRIES];
        logic [63:0] access_count;
        logic [31:0] timeout;
        pick_t       picks_q[$];
        int          errors;

        function new();
            for (int s = 0; s < NUM_SETS; s++)
                for (int w = 0; w < NUM_WAYS; w++)
                begin
                    rrpv[s][w]     = RRPV_MAX;
                    tracked[s][w]  = 1'b0;
                    touched[s][w]  = '0;
                    line_sig[s][w] = '0;
                    reused[s][w]   = 1'b0;
                end
            foreach (reuse_ctr[i])
                reuse_ctr[i] = CTR_RESET;
            access_count = '0;
            timeout      = TIMEOUT_RESET;
            errors       = 0;
        endfunction

        function void set_timeout(logic [31:0] value);
            timeout = value;
        endfunction

        // take the lowest free way, else demote idle lines, age the set, take the lowest distant way
        function int find_victim(int s, logic [15:0] mask);
            int top;
            top = 0;
            for (int w = 0; w < NUM_WAYS; w++)
                if (!mask[w])
                    return w;
            for (int w = 0; w < NUM_WAYS; w++)
                if (tracked[s][w] && (access_count - touched[s][w]) >= {32'd0, timeout})
                    rrpv[s][w] = RRPV_MAX;
            for (int w = 0; w < NUM_WAYS; w++)
                if (rrpv[s][w] > top)
                    top = rrpv[s][w];
            if (top < RRPV_MAX)
                for (int w = 0; w < NUM_WAYS; w++)
                    rrpv[s][w] = 2'(rrpv[s][w] + (RRPV_MAX - top));
            for (int w = 0; w < NUM_WAYS; w++)
                if (rrpv[s][w] == RRPV_MAX)
                    return w;
            return 0;
        endfunction

        function void note_access(logic [10:0] set_idx, logic [63:0] pc_val, logic pf,
                                  logic is_hit, logic [3:0] hway, logic [15:0] mask);
            pick_t       p;
            int          s;
            int          v;
            logic [13:0] sig;
            s = set_idx;
            if (is_hit)
            begin
                access_count++;
                rrpv[s][hway]    = RRPV_HOT;
                touched[s][hway] = access_count;
                if (reuse_ctr[line_sig[s][hway]] < CTR_MAX)
                    reuse_ctr[line_sig[s][hway]]++;
                reused[s][hway] = 1'b1;
                p.way = {1'b0, hway};
                p.byp = 1'b0;
            end
            else
            begin
                sig = pc_val[13:0] ^ pc_val[29:16];
                if (pf || reuse_ctr[sig] == 0)
                begin
                    access_count++;
                    p.way = BYPASS_WAY;
                    p.byp = 1'b1;
                end
                else
                begin
                    v = find_victim(s, mask);
                    access_count++;
                    // eviction of a line never reused weakens its signature
                    if (tracked[s][v] && !reused[s][v] && reuse_ctr[line_sig[s][v]] > 0)
                        reuse_ctr[line_sig[s][v]]--;
                    tracked[s][v]  = 1'b1;
                    touched[s][v]  = access_count;
                    line_sig[s][v] = sig;
                    reused[s][v]   = 1'b0;
                    rrpv[s][v]     = (reuse_ctr[sig] >= 2) ? RRPV_HOT : RRPV_COLD;
                    p.way = v[4:0];
                    p.byp = 1'b0;
                end
            end
            picks_q.push_back(p);
        endfunction

        function void check_result(logic [4:0] way, logic byp);
            pick_t p;
            if (picks_q.size() == 0)
            begin
                $display("%0t: unexpected result way %0d bypassed %0d", $time, way, byp);
                errors++;
                return;
            end
            p = picks_q.pop_front();
            if (way !== p.way)
            begin
                $display("%0t: chosen_way expected %0d actual %0d", $time, p.way, way);
                errors++;
            end
            if (byp !== p.byp)
            begin
                $display("%0t: bypassed expected %0d actual %0d", $time, p.byp, byp);
                errors++;
            end
        endfunction
    endclass

    localparam int IDLE_LIMIT = 100000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [10:0] set_index = '0;
    logic [63:0] pc = '0;
    logic        is_prefetch = 1'b0;
    logic        hit = 1'b0;
    logic [3:0]  hit_way = '0;
    logic [15:0] line_valid_mask = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [4:0]  chosen_way;
    logic        bypassed;

    replacement_scoreboard sb = new();
    logic        quiet = 1'b0;
    logic        hold_req = 1'b0;
    int          idle_cycles = 0;
    logic [63:0] pc_pool[6];
    logic [10:0] set_pool[4] = '{11'd0, 11'd7, 11'd1024, 11'd2047};

    signature_bypass_rrip_replacement u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .set_index(set_index), .pc(pc), .is_prefetch(is_prefetch), .hit(hit),
        .hit_way(hit_way), .line_valid_mask(line_valid_mask),
        .out_valid(out_valid), .out_ready(out_ready),
        .chosen_way(chosen_way), .bypassed(bypassed)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (in_valid && in_ready)
            sb.note_access(set_index, pc, is_prefetch, hit, hit_way, line_valid_mask);
        if (out_valid && out_ready)
            sb.check_result(chosen_way, bypassed);
        if (cfg_valid && cfg_ready)
            sb.set_timeout(cfg_data);
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // result side: random stall bursts, one long hold on request, none when quiet
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_req <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 8) - 1) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(0, 10)) @(posedge clk);
            end
        end
    end

    task automatic send_access(logic [10:0] s, logic [63:0] p, logic pf, logic h,
                               logic [3:0] w, logic [15:0] m);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        in_valid        <= 1'b1;
        set_index       <= s;
        pc              <= p;
        is_prefetch     <= pf;
        hit             <= h;
        hit_way         <= w;
        line_valid_mask <= m;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.picks_q.size() != 0);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_timeout(logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_access();
        logic [10:0] s;
        logic [63:0] p;
        logic [15:0] m;
        s = ($urandom_range(0, 9) < 8) ? set_pool[$urandom_range(0, 3)] : 11'($urandom);
        p = ($urandom_range(0, 9) < 9) ? pc_pool[$urandom_range(0, 5)]
                                       : {$urandom, $urandom};
        m = ($urandom_range(0, 9) < 7) ? 16'hFFFF : 16'($urandom);
        send_access(s, p, $urandom_range(0, 9) == 0, $urandom_range(0, 9) < 4,
                    4'($urandom), m);
    endtask

    initial
    begin
        logic [31:0] timeouts[5] = '{TIMEOUT_RESET, 32'd1, 32'hFFFF_FFFF, 32'd5, 32'd40};
        foreach (pc_pool[i])
            pc_pool[i] = {$urandom, $urandom};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_timeout(timeouts[0]);
        // extremes of set and pc, prefetch, free ways, full set, hit on untracked way
        send_access(11'd0, 64'd0, 1'b0, 1'b0, 4'd0, 16'h0000);
        send_access(11'd2047, '1, 1'b0, 1'b0, 4'd0, 16'h7FFF);
        send_access(11'd2047, '1, 1'b1, 1'b0, 4'd15, 16'hFFFF);
        send_access(11'd2047, 64'd0, 1'b0, 1'b1, 4'd15, 16'hFFFF);
        send_access(11'd0, 64'd0, 1'b0, 1'b1, 4'd9, 16'hFFFF);
        for (int i = 0; i < 8; i++)
            send_access(11'd3, pc_pool[i % 2], 1'b0, 1'b0, 4'd0, 16'hFFFF);
        send_access(11'd3, pc_pool[0], 1'b0, 1'b1, 4'd0, 16'hFFFF);
        send_access(11'd3, pc_pool[1], 1'b1, 1'b1, 4'd15, 16'h0001);
        for (int i = 0; i < 4; i++)
            send_access(11'd3, pc_pool[1], 1'b0, 1'b0, 4'd0, 16'hFFFF);
        drain();

        for (int ph = 1; ph < 5; ph++)
        begin
            write_timeout(timeouts[ph]);
            for (int i = 0; i < 120; i++)
            begin
                if (ph == 1 && i == 20)
                    hold_req <= 1'b1;
                if (ph == 2 && i == 60)
                begin
                    in_valid <= 1'b0;
                    do @(posedge clk); while (sb.picks_q.size() != 0);
                end
                if (ph == 4 && i == 80)
                    quiet <= 1'b1;
                random_access();
            end
            drain();
        end
        write_timeout(TIMEOUT_RESET);

        if (sb.errors == 0 && sb.picks_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
